// ===== rtl/core/ccm_pkg.sv =====
// ============================================================================
// ccm_pkg
// Shared constants, register codes and sRGB table math for the color
// contrast metrics block.
// ============================================================================
package ccm_pkg;

    // Channel and stream widths
    localparam int CH_W       = 8;
    localparam int S_DATA_W   = 48;
    localparam int M_DATA_W   = 32;
    localparam int DIFF_W     = 10;
    localparam int QL_W       = 2;
    localparam int BRIGHT_W   = 8;
    localparam int RATIO_W    = 5;

    // Configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 10;
    localparam logic [CFG_IDX_W-1:0] CFG_DIFF_LIMIT   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BRIGHT_LIMIT = 2'd1;
    localparam logic [DIFF_W-1:0]    DIFF_LIMIT_RST   = 10'd500;
    localparam logic [BRIGHT_W-1:0]  BRIGHT_LIMIT_RST = 8'd255;

    // Quality grades
    localparam logic [QL_W-1:0] QL_GOOD       = 2'd0;
    localparam logic [QL_W-1:0] QL_SUFFICIENT = 2'd1;
    localparam logic [QL_W-1:0] QL_IMPERFECT  = 2'd2;

    // Perceived brightness: (299R + 587G + 114B) / 1000
    localparam int YSUM_W   = 18;
    localparam int BR_WR    = 299;
    localparam int BR_WG    = 587;
    localparam int BR_WB    = 114;
    localparam int BR_DIV   = 1000;
    // floor(2^24 / 1000); the estimate is low by at most one
    localparam int BR_RECIP = 16777;
    localparam int BR_SHIFT = 24;
    localparam int BR_PROD_W = 33;

    // Contrast ratio clamp
    localparam logic [RATIO_W-1:0] RATIO_MIN = 5'd1;
    localparam logic [RATIO_W-1:0] RATIO_MAX = 5'd21;

    // Table-build arithmetic in Q30
    localparam int          Q_IB      = 30;
    localparam logic [63:0] ONE_Q     = 64'd1 << Q_IB;
    localparam logic [63:0] HALF_Q    = 64'd1 << (Q_IB - 1);
    localparam int          ROOT_ITER = 32;

    function automatic logic [CH_W-1:0] abs_diff8(input logic [CH_W-1:0] a,
                                                  input logic [CH_W-1:0] b);
        return (a > b) ? (a - b) : (b - a);
    endfunction

    function automatic logic [63:0] mulq(input logic [63:0] a, input logic [63:0] b);
        logic [63:0] p;
        p = a * b;
        return p >> Q_IB;
    endfunction

    function automatic logic [63:0] pow5q(input logic [63:0] y);
        logic [63:0] y2;
        logic [63:0] y4;
        y2 = mulq(y, y);
        y4 = mulq(y2, y2);
        return mulq(y4, y);
    endfunction

    // Largest Q30 value in [0,1] whose fifth power does not exceed v
    function automatic logic [63:0] root5q(input logic [63:0] v);
        logic [63:0] lo;
        logic [63:0] hi;
        logic [63:0] mid;
        lo = 64'd0;
        hi = ONE_Q;
        for (int i = 0; i < ROOT_ITER; i++) begin
            if (lo < hi) begin
                mid = (lo + hi + 64'd1) >> 1;
                if (pow5q(mid) <= v) begin
                    lo = mid;
                end else begin
                    hi = mid - 64'd1;
                end
            end
        end
        return lo;
    endfunction

    // sRGB linear light for one 8-bit code, in Q1.frac (elaboration only)
    function automatic logic [63:0] lin_entry(input logic [CH_W-1:0] c, input int frac);
        logic [63:0] c64;
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] p;
        c64 = 64'(c);
        if (c64 <= 64'd10) begin
            return (((c64 * 64'd10) << frac) + 64'd16473) / 64'd32946;
        end
        x  = (((64'd1000 * c64 + 64'd14025) << Q_IB) + 64'd134512) / 64'd269025;
        x2 = (x * x + HALF_Q) >> Q_IB;
        p  = (x2 * root5q(x2) + HALF_Q) >> Q_IB;
        return (p + (64'd1 << (Q_IB - frac - 1))) >> (Q_IB - frac);
    endfunction

endpackage

// ===== rtl/core/color_contrast_metrics.sv =====
// ============================================================================
// color_contrast_metrics
// Per-pair color difference, quality grade, brightness difference and
// WCAG contrast ratio for a foreground/background 8-bit RGB pair.
// ============================================================================
//
//  channel  | dir | handshake          | payload
//  ---------+-----+--------------------+---------------------------------------
//  s_       | in  | s_tvalid/s_tready  | fg_red..bg_blue, 6 x 8 bits
//  m_       | out | m_tvalid/m_tready  | difference, grade, brightness, ratio
//  cfg_     | in  | cfg_valid/cfg_ready| register index and write data
//
//  One request per cycle sustained while m_tready stays high; the pipeline is
//  four arithmetic stages, then a 5-stage restoring divider, one quotient bit
//  per stage, which sets the depth. Each stage carries a valid bit and takes
//  new data when it is empty or its successor moves, so bubbles close up and
//  a stalled m_ side holds everything in place. Reset clears the valid bits
//  and loads the default limits. cfg_ready is always high.
//
module color_contrast_metrics #(
    parameter int FRAC_BITS = 16
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // fg_red, fg_green, fg_blue, bg_red, bg_green, bg_blue (low bit up)
    input  logic [ccm_pkg::S_DATA_W-1:0]       s_tdata,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // color_difference, quality_level, brightness_difference,
    // contrast_ratio, zero pad (low bit up)
    output logic [ccm_pkg::M_DATA_W-1:0]       m_tdata,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [ccm_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [ccm_pkg::CFG_DATA_W-1:0]     cfg_data
);

    import ccm_pkg::*;

    localparam int LW      = FRAC_BITS + 1;      // table entry, up to 1.0
    localparam int PW      = FRAC_BITS + LW;     // weight x entry
    localparam int SW      = PW + 2;             // sum of three products
    localparam int LUMW    = FRAC_BITS + 2;      // luminance plus offset
    localparam int NW      = FRAC_BITS + 4;      // numerator/denominator
    localparam int CW      = NW + RATIO_W;       // divider compare width
    localparam int DIV_STG = RATIO_W;
    localparam int NSTG    = 4 + DIV_STG;
    localparam int PAD_W   = M_DATA_W - DIFF_W - QL_W - BRIGHT_W - RATIO_W;

    localparam logic [63:0] WR_FULL  = ((64'd2126 << FRAC_BITS) + 64'd5000) / 64'd10000;
    localparam logic [63:0] WG_FULL  = ((64'd7152 << FRAC_BITS) + 64'd5000) / 64'd10000;
    localparam logic [63:0] WB_FULL  = ((64'd722 << FRAC_BITS) + 64'd5000) / 64'd10000;
    localparam logic [63:0] OFF_FULL = ((64'd5 << FRAC_BITS) + 64'd50) / 64'd100;
    localparam logic [FRAC_BITS-1:0] LUM_WR  = WR_FULL[FRAC_BITS-1:0];
    localparam logic [FRAC_BITS-1:0] LUM_WG  = WG_FULL[FRAC_BITS-1:0];
    localparam logic [FRAC_BITS-1:0] LUM_WB  = WB_FULL[FRAC_BITS-1:0];
    localparam logic [LUMW-1:0]      LUM_OFF = OFF_FULL[LUMW-1:0];
    localparam logic [SW-1:0]        LUM_RND = SW'(1) << (FRAC_BITS - 1);

    function automatic logic [256*LW-1:0] build_rom();
        logic [256*LW-1:0] r;
        logic [63:0]       e;
        r = '0;
        for (int i = 0; i < 256; i++) begin
            e = lin_entry(CH_W'(i), FRAC_BITS);
            r[i*LW +: LW] = e[LW-1:0];
        end
        return r;
    endfunction

    localparam logic [256*LW-1:0] LIN_ROM = build_rom();

    typedef struct packed {
        logic [CH_W-1:0]   ad_r;
        logic [CH_W-1:0]   ad_g;
        logic [CH_W-1:0]   ad_b;
        logic [YSUM_W-1:0] ysum_f;
        logic [YSUM_W-1:0] ysum_b;
        logic [LW-1:0]     lin_fr;
        logic [LW-1:0]     lin_fg;
        logic [LW-1:0]     lin_fb;
        logic [LW-1:0]     lin_br;
        logic [LW-1:0]     lin_bg;
        logic [LW-1:0]     lin_bb;
    } p1_t;

    typedef struct packed {
        logic [DIFF_W-1:0] cd;
        logic [QL_W-1:0]   ql;
        logic [YSUM_W-1:0] ysum_f;
        logic [YSUM_W-1:0] ysum_b;
        logic [CH_W-1:0]   yest_f;
        logic [CH_W-1:0]   yest_b;
        logic [PW-1:0]     pr_fr;
        logic [PW-1:0]     pr_fg;
        logic [PW-1:0]     pr_fb;
        logic [PW-1:0]     pr_br;
        logic [PW-1:0]     pr_bg;
        logic [PW-1:0]     pr_bb;
    } p2_t;

    typedef struct packed {
        logic [DIFF_W-1:0] cd;
        logic [QL_W-1:0]   ql;
        logic [CH_W-1:0]   y_f;
        logic [CH_W-1:0]   y_b;
        logic [LUMW-1:0]   lum_f;
        logic [LUMW-1:0]   lum_b;
    } p3_t;

    typedef struct packed {
        logic [DIFF_W-1:0]   cd;
        logic [QL_W-1:0]     ql;
        logic [BRIGHT_W-1:0] bd;
        logic [NW-1:0]       rem;
        logic [NW-1:0]       den;
        logic [RATIO_W-1:0]  quo;
    } div_t;

    logic [DIFF_W-1:0]   diff_limit_reg;
    logic [BRIGHT_W-1:0] bright_limit_reg;

    logic [NSTG-1:0] vld_reg;
    logic [NSTG-1:0] vld_in;
    logic [NSTG-1:0] rdy;

    p1_t  p1_reg, p1_next;
    p2_t  p2_reg, p2_next;
    p3_t  p3_reg, p3_next;
    div_t p4_reg, p4_next;
    div_t div_reg  [DIV_STG];
    div_t div_next [DIV_STG];
    div_t div_in   [DIV_STG];

    // ---------------- configuration ----------------
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            diff_limit_reg   <= DIFF_LIMIT_RST;
            bright_limit_reg <= BRIGHT_LIMIT_RST;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                CFG_DIFF_LIMIT:   diff_limit_reg   <= cfg_data[DIFF_W-1:0];
                CFG_BRIGHT_LIMIT: bright_limit_reg <= cfg_data[BRIGHT_W-1:0];
                default: ;
            endcase
        end
    end

    // ---------------- flow control ----------------
    assign vld_in = {vld_reg[NSTG-2:0], s_tvalid};

    always_comb begin
        rdy[NSTG-1] = !vld_reg[NSTG-1] || m_tready;
        for (int i = NSTG - 2; i >= 0; i--) begin
            rdy[i] = !vld_reg[i] || rdy[i+1];
        end
    end

    assign s_tready = rdy[0];
    assign m_tvalid = vld_reg[NSTG-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            for (int i = 0; i < NSTG; i++) begin
                if (rdy[i]) begin
                    vld_reg[i] <= vld_in[i];
                end
            end
        end
    end

    // ---------------- stage 1: channel diffs, brightness sums, table ----------------
    always_comb begin
        logic [CH_W-1:0] fr, fg, fb, br, bg, bb;
        fr = s_tdata[0*CH_W +: CH_W];
        fg = s_tdata[1*CH_W +: CH_W];
        fb = s_tdata[2*CH_W +: CH_W];
        br = s_tdata[3*CH_W +: CH_W];
        bg = s_tdata[4*CH_W +: CH_W];
        bb = s_tdata[5*CH_W +: CH_W];
        p1_next.ad_r   = abs_diff8(fr, br);
        p1_next.ad_g   = abs_diff8(fg, bg);
        p1_next.ad_b   = abs_diff8(fb, bb);
        p1_next.ysum_f = YSUM_W'(BR_WR) * YSUM_W'(fr) + YSUM_W'(BR_WG) * YSUM_W'(fg)
                       + YSUM_W'(BR_WB) * YSUM_W'(fb);
        p1_next.ysum_b = YSUM_W'(BR_WR) * YSUM_W'(br) + YSUM_W'(BR_WG) * YSUM_W'(bg)
                       + YSUM_W'(BR_WB) * YSUM_W'(bb);
        p1_next.lin_fr = LIN_ROM[int'(fr)*LW +: LW];
        p1_next.lin_fg = LIN_ROM[int'(fg)*LW +: LW];
        p1_next.lin_fb = LIN_ROM[int'(fb)*LW +: LW];
        p1_next.lin_br = LIN_ROM[int'(br)*LW +: LW];
        p1_next.lin_bg = LIN_ROM[int'(bg)*LW +: LW];
        p1_next.lin_bb = LIN_ROM[int'(bb)*LW +: LW];
    end

    // ---------------- stage 2: sum/grade, brightness estimate, weights ----------------
    always_comb begin
        logic [DIFF_W-1:0]    diff;
        logic [DIFF_W-1:0]    quarter;
        logic [DIFF_W-1:0]    thr_good;
        logic [DIFF_W-1:0]    thr_suff;
        logic [BR_PROD_W-1:0] ye_f;
        logic [BR_PROD_W-1:0] ye_b;
        diff     = DIFF_W'(p1_reg.ad_r) + DIFF_W'(p1_reg.ad_g) + DIFF_W'(p1_reg.ad_b);
        quarter  = diff_limit_reg >> 2;
        thr_good = quarter + (quarter << 1);
        thr_suff = diff_limit_reg >> 1;
        p2_next.cd = (diff >= diff_limit_reg) ? diff_limit_reg : diff;
        if (diff >= thr_good) begin
            p2_next.ql = QL_GOOD;
        end else if (diff >= thr_suff) begin
            p2_next.ql = QL_SUFFICIENT;
        end else begin
            p2_next.ql = QL_IMPERFECT;
        end
        // reciprocal estimate of ysum / 1000, fixed up next stage
        ye_f = BR_PROD_W'(p1_reg.ysum_f) * BR_PROD_W'(BR_RECIP);
        ye_b = BR_PROD_W'(p1_reg.ysum_b) * BR_PROD_W'(BR_RECIP);
        p2_next.ysum_f = p1_reg.ysum_f;
        p2_next.ysum_b = p1_reg.ysum_b;
        p2_next.yest_f = ye_f[BR_SHIFT +: CH_W];
        p2_next.yest_b = ye_b[BR_SHIFT +: CH_W];
        p2_next.pr_fr  = PW'(p1_reg.lin_fr) * PW'(LUM_WR);
        p2_next.pr_fg  = PW'(p1_reg.lin_fg) * PW'(LUM_WG);
        p2_next.pr_fb  = PW'(p1_reg.lin_fb) * PW'(LUM_WB);
        p2_next.pr_br  = PW'(p1_reg.lin_br) * PW'(LUM_WR);
        p2_next.pr_bg  = PW'(p1_reg.lin_bg) * PW'(LUM_WG);
        p2_next.pr_bb  = PW'(p1_reg.lin_bb) * PW'(LUM_WB);
    end

    // ---------------- stage 3: luminance, brightness correction ----------------
    always_comb begin
        logic [SW-1:0]     s_f;
        logic [SW-1:0]     s_b;
        logic [YSUM_W-1:0] rem_f;
        logic [YSUM_W-1:0] rem_b;
        s_f   = SW'(p2_reg.pr_fr) + SW'(p2_reg.pr_fg) + SW'(p2_reg.pr_fb) + LUM_RND;
        s_b   = SW'(p2_reg.pr_br) + SW'(p2_reg.pr_bg) + SW'(p2_reg.pr_bb) + LUM_RND;
        rem_f = p2_reg.ysum_f - YSUM_W'(p2_reg.yest_f) * YSUM_W'(BR_DIV);
        rem_b = p2_reg.ysum_b - YSUM_W'(p2_reg.yest_b) * YSUM_W'(BR_DIV);
        p3_next.cd    = p2_reg.cd;
        p3_next.ql    = p2_reg.ql;
        p3_next.y_f   = (rem_f >= YSUM_W'(BR_DIV)) ? p2_reg.yest_f + 1'b1 : p2_reg.yest_f;
        p3_next.y_b   = (rem_b >= YSUM_W'(BR_DIV)) ? p2_reg.yest_b + 1'b1 : p2_reg.yest_b;
        p3_next.lum_f = LUMW'(s_f >> FRAC_BITS) + LUM_OFF;
        p3_next.lum_b = LUMW'(s_b >> FRAC_BITS) + LUM_OFF;
    end

    // ---------------- stage 4: brightness saturate, ratio operands ----------------
    always_comb begin
        logic [BRIGHT_W-1:0] bd;
        logic [LUMW-1:0]     hi;
        logic [LUMW-1:0]     lo;
        bd = abs_diff8(p3_reg.y_f, p3_reg.y_b);
        hi = (p3_reg.lum_f > p3_reg.lum_b) ? p3_reg.lum_f : p3_reg.lum_b;
        lo = (p3_reg.lum_f > p3_reg.lum_b) ? p3_reg.lum_b : p3_reg.lum_f;
        p4_next.cd  = p3_reg.cd;
        p4_next.ql  = p3_reg.ql;
        p4_next.bd  = (bd >= bright_limit_reg) ? bright_limit_reg : bd;
        // round(hi/lo) = floor((2hi + lo) / 2lo)
        p4_next.rem = (NW'(hi) << 1) + NW'(lo);
        p4_next.den = NW'(lo) << 1;
        p4_next.quo = '0;
    end

    // ---------------- stages 5..9: restoring divide, MSB first ----------------
    always_comb begin
        logic [CW-1:0] trial;
        for (int i = 0; i < DIV_STG; i++) begin
            div_in[i] = (i == 0) ? p4_reg : div_reg[(i == 0) ? 0 : i - 1];
            trial     = CW'(div_in[i].den) << (DIV_STG - 1 - i);
            div_next[i] = div_in[i];
            if (CW'(div_in[i].rem) >= trial) begin
                div_next[i].rem = NW'(CW'(div_in[i].rem) - trial);
                div_next[i].quo = div_in[i].quo | (RATIO_W'(1) << (DIV_STG - 1 - i));
            end
            if (i == DIV_STG - 1) begin
                if (div_next[i].quo < RATIO_MIN) begin
                    div_next[i].quo = RATIO_MIN;
                end else if (div_next[i].quo > RATIO_MAX) begin
                    div_next[i].quo = RATIO_MAX;
                end
            end
        end
    end

    // ---------------- payload registers ----------------
    always_ff @(posedge aclk) begin
        if (rdy[0]) begin
            p1_reg <= p1_next;
        end
        if (rdy[1]) begin
            p2_reg <= p2_next;
        end
        if (rdy[2]) begin
            p3_reg <= p3_next;
        end
        if (rdy[3]) begin
            p4_reg <= p4_next;
        end
        for (int i = 0; i < DIV_STG; i++) begin
            if (rdy[4+i]) begin
                div_reg[i] <= div_next[i];
            end
        end
    end

    assign m_tdata = {{PAD_W{1'b0}},
                      div_reg[DIV_STG-1].quo,
                      div_reg[DIV_STG-1].bd,
                      div_reg[DIV_STG-1].ql,
                      div_reg[DIV_STG-1].cd};

endmodule
